>>> hw/rtl/rc_pkg.sv
// ----------------------------------------------------------------------------
// rc_pkg: shared types, constants and helpers of the radix converter
// Holds the function codes, the output radix type and the digit shifter
// helpers used by the core, and the types of the digit-coded decoder.
// ----------------------------------------------------------------------------
package rc_pkg;

    localparam int VALUE_BITS = 31;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_BITS   = 4 * BCD_DIGITS;
    localparam int CNT_W      = 5;
    localparam int SR_BITS    = 33;
    localparam int DCNT_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 7;

    localparam logic [2:0] FUNC_DEC_BIN = 3'd0;
    localparam logic [2:0] FUNC_DEC_OCT = 3'd1;
    localparam logic [2:0] FUNC_DEC_HEX = 3'd2;
    localparam logic [2:0] FUNC_BIN_DEC = 3'd3;
    localparam logic [2:0] FUNC_OCT_DEC = 3'd4;
    localparam logic [2:0] FUNC_BIN_OCT = 3'd5;
    localparam logic [2:0] FUNC_BIN_HEX = 3'd6;
    localparam logic [2:0] FUNC_OCT_BIN = 3'd7;

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
    localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

    typedef enum logic [1:0] {
        RAD_BIN,
        RAD_OCT,
        RAD_HEX
    } radix_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SKIP,
        ST_EMIT,
        ST_NUMBER
    } core_state_t;

    typedef enum logic [1:0] {
        DEC_IDLE,
        DEC_SHIFT,
        DEC_ACC,
        DEC_DONE
    } dec_state_t;

    typedef struct packed {
        logic start;
        logic octal;
    } dec_cmd_t;

    typedef struct packed {
        logic                  done;
        logic [VALUE_BITS-1:0] number;
    } dec_result_t;

    // Places the value so that its most significant digit sits at the top of
    // the shift register, whatever the digit size.
    function automatic logic [SR_BITS-1:0] sr_load(input logic [VALUE_BITS-1:0] x,
                                                   input radix_t rad);
        logic [SR_BITS-1:0] r;
        unique case (rad)
            RAD_BIN: r = {x, 2'b00};
            RAD_OCT: r = {2'b00, x};
            RAD_HEX: r = {1'b0, x, 1'b0};
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [DCNT_W-1:0] digit_count(input radix_t rad);
        logic [DCNT_W-1:0] n;
        unique case (rad)
            RAD_BIN: n = 6'd31;
            RAD_OCT: n = 6'd11;
            RAD_HEX: n = 6'd8;
            default: n = 6'd1;
        endcase
        return n;
    endfunction

    function automatic logic [DIGIT_W-1:0] top_digit(input logic [SR_BITS-1:0] sr,
                                                     input radix_t rad);
        logic [DIGIT_W-1:0] d;
        unique case (rad)
            RAD_BIN: d = {3'b000, sr[SR_BITS-1]};
            RAD_OCT: d = {1'b0, sr[SR_BITS-1 -: 3]};
            RAD_HEX: d = sr[SR_BITS-1 -: 4];
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic logic [SR_BITS-1:0] sr_shift(input logic [SR_BITS-1:0] sr,
                                                    input radix_t rad);
        logic [SR_BITS-1:0] r;
        unique case (rad)
            RAD_BIN: r = {sr[SR_BITS-2:0], 1'b0};
            RAD_OCT: r = {sr[SR_BITS-4:0], 3'b000};
            RAD_HEX: r = {sr[SR_BITS-5:0], 4'b0000};
            default: r = sr;
        endcase
        return r;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10)
        begin
            c = ASCII_ZERO + {3'b000, d};
        end
        else
        begin
            c = ASCII_A + {3'b000, d} - 7'd10;
        end
        return c;
    endfunction

endpackage

>>> hw/rtl/rc_decoder.sv
// ----------------------------------------------------------------------------
// rc_decoder: digit-coded value decoder
// Splits the value into decimal digits with a bit-serial shift-add-3 pass,
// then weights the digits by powers of 2 or 8, one digit per cycle.
// ----------------------------------------------------------------------------
module rc_decoder
    import rc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dec_cmd_t              cmd,
    input  logic [VALUE_BITS-1:0] value,
    output dec_result_t           result
);

    dec_state_t            state_reg, state_next;
    logic [VALUE_BITS-1:0] bin_reg, bin_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [VALUE_BITS:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  oct_reg, oct_next;
    logic [3:0]            bcd_top;

    assign bcd_top = bcd_reg[BCD_BITS-1 -: 4];

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DEC_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = DEC_SHIFT;
                end
            end
            DEC_SHIFT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = DEC_ACC;
                end
            end
            DEC_ACC:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = DEC_DONE;
                end
            end
            DEC_DONE:  state_next = DEC_IDLE;
            default:   state_next = DEC_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        bin_next = bin_reg;
        bcd_next = bcd_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        oct_next = oct_reg;
        result.done   = 1'b0;
        result.number = acc_reg[VALUE_BITS] ? '1 : acc_reg[VALUE_BITS-1:0];
        unique case (state_reg)
            DEC_IDLE:
            begin
                if (cmd.start)
                begin
                    bin_next = value;
                    bcd_next = '0;
                    cnt_next = CNT_W'(VALUE_BITS - 1);
                    oct_next = cmd.octal;
                end
            end
            DEC_SHIFT:
            begin
                bcd_next = {bcd_adj[BCD_BITS-2:0], bin_reg[VALUE_BITS-1]};
                bin_next = {bin_reg[VALUE_BITS-2:0], 1'b0};
                acc_next = '0;
                if (cnt_reg == '0)
                begin
                    cnt_next = CNT_W'(BCD_DIGITS - 1);
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            DEC_ACC:
            begin
                // Horner step over the decimal digits, most significant first.
                if (oct_reg)
                begin
                    acc_next = {acc_reg[VALUE_BITS-3:0], 3'b000} + {28'd0, bcd_top};
                end
                else
                begin
                    acc_next = {acc_reg[VALUE_BITS-1:0], 1'b0} + {28'd0, bcd_top};
                end
                bcd_next = {bcd_reg[BCD_BITS-5:0], 4'b0000};
                cnt_next = cnt_reg - 1'b1;
            end
            DEC_DONE:
            begin
                result.done = 1'b1;
            end
            default:
            begin
                result.done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DEC_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        acc_reg <= acc_next;
        oct_reg <= oct_next;
    end

endmodule

>>> hw/rtl/radix_converter_core.sv
// ----------------------------------------------------------------------------
// radix_converter_core: binary, octal, decimal and hex radix converter
// Converts one value per item as selected by func and streams out the digits,
// or for decimal results the decoded number.
// Plain inputs (func 0 to 2) go through the leading-zero skip of the digit
// shifter before their first digit. Digit-coded inputs (func 3 to 7) are first
// split into decimal digits and weighted in the decoder; decimal results then
// come out as the number, the others go through the skip. Throughput: one item
// at a time, then one output digit per cycle while m_tready is high.
// Reset: rst_n clears the state registers and counters; idle after.
module radix_converter_core
    import rc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input item.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value, [31] zero
    input  logic [2:0]  s_tuser,   // [2:0] func
    // Result item.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [3:0] digit, [10:4] digit_char, [41:11] number,
                                   // [47:42] zero
    output logic        m_tlast
);

    core_state_t           state_reg, state_next;
    logic [2:0]            func_reg, func_next;
    radix_t                rad_reg, rad_next;
    logic [SR_BITS-1:0]    sr_reg, sr_next;
    logic [DCNT_W-1:0]     cnt_reg, cnt_next;
    logic [VALUE_BITS-1:0] num_reg, num_next;

    logic                  in_accept;
    logic                  out_accept;
    logic                  decimal_out;
    logic [DIGIT_W-1:0]    cur_digit;
    radix_t                in_rad;
    dec_cmd_t              dec_cmd;
    dec_result_t           dec_res;

    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;
    assign cur_digit  = top_digit(sr_reg, rad_reg);
    assign decimal_out = (func_reg == FUNC_BIN_DEC) || (func_reg == FUNC_OCT_DEC);

    // Output radix of each function; decimal outputs never use it.
    always_comb
    begin
        unique case (s_tuser) inside
            FUNC_DEC_BIN, FUNC_OCT_BIN: in_rad = RAD_BIN;
            FUNC_DEC_OCT, FUNC_BIN_OCT: in_rad = RAD_OCT;
            default:                    in_rad = RAD_HEX;
        endcase
    end

    // Digit-coded inputs are decoded first; octal coding only for oct-dec
    // and oct-bin.
    assign dec_cmd.start = in_accept && (s_tuser >= FUNC_BIN_DEC);
    assign dec_cmd.octal = (s_tuser == FUNC_OCT_DEC) || (s_tuser == FUNC_OCT_BIN);

    rc_decoder u_decoder
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (dec_cmd),
        .value  (s_tdata[VALUE_BITS-1:0]),
        .result (dec_res)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = (s_tuser >= FUNC_BIN_DEC) ? ST_DECODE : ST_SKIP;
                end
            end
            ST_DECODE:
            begin
                if (dec_res.done)
                begin
                    state_next = decimal_out ? ST_NUMBER : ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // Leading zero digits are dropped, but one digit always remains.
                if ((cnt_reg == 6'd1) || (cur_digit != '0))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_accept && (cnt_reg == 6'd1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_NUMBER:
            begin
                if (out_accept)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb
    begin
        func_next = func_reg;
        rad_next  = rad_reg;
        sr_next   = sr_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        m_tlast   = 1'b0;
        m_tdata   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (in_accept)
                begin
                    func_next = s_tuser;
                    rad_next  = in_rad;
                    sr_next   = sr_load(s_tdata[VALUE_BITS-1:0], in_rad);
                    cnt_next  = digit_count(in_rad);
                end
            end
            ST_DECODE:
            begin
                if (dec_res.done)
                begin
                    num_next = dec_res.number;
                    sr_next  = sr_load(dec_res.number, rad_reg);
                end
            end
            ST_SKIP:
            begin
                if ((cnt_reg != 6'd1) && (cur_digit == '0))
                begin
                    sr_next  = sr_shift(sr_reg, rad_reg);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_EMIT:
            begin
                m_tvalid      = 1'b1;
                m_tlast       = (cnt_reg == 6'd1);
                m_tdata[3:0]  = cur_digit;
                m_tdata[10:4] = digit_char(cur_digit);
                if (out_accept && (cnt_reg != 6'd1))
                begin
                    sr_next  = sr_shift(sr_reg, rad_reg);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_NUMBER:
            begin
                m_tvalid       = 1'b1;
                m_tlast        = 1'b1;
                m_tdata[41:11] = num_reg;
            end
            default:
            begin
                m_tvalid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg <= func_next;
        rad_reg  <= rad_next;
        sr_reg   <= sr_next;
        num_reg  <= num_next;
    end

endmodule

>>> hw/rtl/rc_checker.sv
// ----------------------------------------------------------------------------
// rc_checker: port-level checks of the radix converter
// Watches the stream ports of the core and is bound to every instance.
// ----------------------------------------------------------------------------
module rc_checker
    import rc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tlast
);

    // The core works on one item at a time, so it never takes input while a
    // result is offered.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input taken while a result is pending");

    // An accepted input keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted item");

    // The final result of an item ends the output burst.
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !m_tvalid)
        else $error("result offered right after the last one");

    // A digit result carries the ASCII code of its digit.
    a_char_match: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[10:4] != '0)) |-> (m_tdata[10:4] == digit_char(m_tdata[3:0])))
        else $error("digit character does not match digit");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind radix_converter_core rc_checker u_rc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of radix_converter_core
// Sends conversion requests for all eight functions, first a directed set of
// corner values and then random values, and compares every digit or decoded
// number that comes back against an independent conversion model. Both
// stream sides insert random idle cycles, with idle-free stretches between.
// ----------------------------------------------------------------------------
module tb;

    import rc_pkg::*;

    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          MAX_DIGITS   = 31;
    localparam int          RANDOM_ITEMS = 79;
    localparam int          SETTLE       = 60;
    localparam logic [30:0] VALUE_MAX    = 31'h7FFF_FFFF;

    // One result item of the core, split into its fields.
    typedef struct packed {
        logic [DIGIT_W-1:0]    digit;
        logic [CHAR_W-1:0]     chr;
        logic [VALUE_BITS-1:0] number;
        logic                  last;
    } conv_result_t;

    // Works out the digits or the decoded number of each accepted request and
    // checks the results of the core against them, in order.
    class conversion_checker;
        conv_result_t pending_results[$];
        int           errors;
        int           results_seen;

        function new();
            errors       = 0;
            results_seen = 0;
        endfunction

        task report(string msg);
            $display("mismatch at result %0d: %s", results_seen, msg);
            errors++;
        endtask

        // Decimal digit i of x counts radix^i, saturating at the value range.
        function longint unsigned weigh_digits(longint unsigned x, longint unsigned radix);
            longint unsigned sum;
            longint unsigned w;
            longint unsigned lim;
            sum = 0;
            w   = 1;
            lim = (64'd1 << VALUE_BITS) - 1;
            while (x > 0)
            begin
                sum += (x % 10) * w;
                if (sum > lim)
                begin
                    sum = lim;
                end
                w *= radix;
                x /= 10;
            end
            return sum;
        endfunction

        // Queues one result per digit of x, most significant first. Zero still
        // gives a single digit.
        function void push_digits(longint unsigned x, longint unsigned radix);
            logic [DIGIT_W-1:0] dig[64];
            int                 cnt;
            conv_result_t       r;
            cnt = 0;
            do
            begin
                dig[cnt] = DIGIT_W'(x % radix);
                cnt++;
                x /= radix;
            end
            while (x > 0 && cnt < 64);
            if (cnt > MAX_DIGITS)
            begin
                cnt = MAX_DIGITS;
            end
            for (int k = cnt - 1; k >= 0; k--)
            begin
                r.digit  = dig[k];
                r.chr    = (dig[k] < 10) ? ASCII_ZERO + CHAR_W'(dig[k])
                                         : ASCII_A + CHAR_W'(dig[k]) - CHAR_W'(10);
                r.number = '0;
                r.last   = (k == 0);
                pending_results.push_back(r);
            end
        endfunction

        function void note_item(logic [2:0] func, logic [VALUE_BITS-1:0] value);
            longint unsigned v;
            conv_result_t    r;
            v = value;
            case (func)
                FUNC_DEC_BIN: push_digits(v, 2);
                FUNC_DEC_OCT: push_digits(v, 8);
                FUNC_DEC_HEX: push_digits(v, 16);
                FUNC_BIN_DEC, FUNC_OCT_DEC:
                begin
                    r.digit  = '0;
                    r.chr    = '0;
                    r.number = VALUE_BITS'(weigh_digits(v, (func == FUNC_BIN_DEC) ? 2 : 8));
                    r.last   = 1'b1;
                    pending_results.push_back(r);
                end
                FUNC_BIN_OCT: push_digits(weigh_digits(v, 2), 8);
                FUNC_BIN_HEX: push_digits(weigh_digits(v, 2), 16);
                default:      push_digits(weigh_digits(v, 8), 2);
            endcase
        endfunction

        task check_result(logic [47:0] data, logic tlast);
            conv_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report("result arrived with nothing outstanding");
            end
            else
            begin
                want = pending_results.pop_front();
                if (data[3:0] !== want.digit)
                begin
                    report($sformatf("digit %0h, wanted %0h", data[3:0], want.digit));
                end
                if (data[10:4] !== want.chr)
                begin
                    report($sformatf("digit_char %0h, wanted %0h", data[10:4], want.chr));
                end
                if (data[41:11] !== want.number)
                begin
                    report($sformatf("number %0d, wanted %0d", data[41:11], want.number));
                end
                if (tlast !== want.last)
                begin
                    report($sformatf("last %b, wanted %b", tlast, want.last));
                end
            end
        endtask
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [2:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    int                cycle_count = 0;
    bit                send_calm   = 1'b0;
    bit                recv_calm   = 1'b1;
    conversion_checker conv_check  = new();

    radix_converter_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Idle cycles before the next handshake; a side in a calm stretch never
    // idles. Stretches switch now and then so both modes keep alternating.
    function automatic int unsigned pick_wait(ref bit calm);
        if ($urandom_range(0, 24) == 0)
        begin
            calm = !calm;
        end
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // Decimal-coded digits: mostly legal for the radix, sometimes any of 0..9.
    function automatic logic [30:0] coded_value(int unsigned top);
        longint unsigned v;
        int unsigned     n;
        v = 0;
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
        begin
            v = v * 10 + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 9)
                                                     : $urandom_range(0, top));
        end
        if (v > VALUE_MAX)
        begin
            v = v % 1_000_000_000;
        end
        return 31'(v);
    endfunction

    function automatic logic [30:0] random_value(logic [2:0] func);
        logic [30:0] raw;
        raw = 31'($urandom()) >> $urandom_range(0, 30);
        if (func <= FUNC_DEC_HEX || $urandom_range(0, 7) == 0)
        begin
            return raw;
        end
        else if (func == FUNC_OCT_DEC || func == FUNC_OCT_BIN)
        begin
            return coded_value(7);
        end
        return coded_value(1);
    endfunction

    // Presents one request and returns at the edge where it is taken.
    task automatic send_item(logic [2:0] func, logic [30:0] value);
        int unsigned gap;
        gap = pick_wait(send_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {1'b0, value};
        do @(posedge clk); while (!s_tready);
        conv_check.note_item(func, value);
    endtask

    // Holds off the sender until every outstanding result has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (conv_check.pending_results.size() != 0);
    endtask

    task automatic send_random(int n);
        logic [2:0] func;
        for (int i = 0; i < n; i++)
        begin
            func = 3'($urandom_range(0, 7));
            send_item(func, random_value(func));
        end
    endtask

    // Result side: random back-pressure, one check per accepted item.
    initial
    begin
        int unsigned stall;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            stall = pick_wait(recv_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            conv_check.check_result(m_tdata, m_tlast);
        end
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero in every mode, the full value range, hex letters, digit-coded
        // values with digits outside their radix, and the longest outputs.
        send_item(FUNC_DEC_BIN, 31'd0);
        send_item(FUNC_DEC_BIN, VALUE_MAX);
        send_item(FUNC_DEC_BIN, 31'd1);
        send_item(FUNC_DEC_OCT, 31'd0);
        send_item(FUNC_DEC_OCT, VALUE_MAX);
        send_item(FUNC_DEC_HEX, 31'd0);
        send_item(FUNC_DEC_HEX, VALUE_MAX);
        send_item(FUNC_DEC_HEX, 31'h1A2B_3C4D);
        send_item(FUNC_BIN_DEC, 31'd0);
        send_item(FUNC_BIN_DEC, 31'd1111111111);
        send_item(FUNC_BIN_DEC, 31'd999999999);
        send_item(FUNC_BIN_DEC, VALUE_MAX);
        send_item(FUNC_OCT_DEC, 31'd0);
        send_item(FUNC_OCT_DEC, 31'd1777777777);
        send_item(FUNC_OCT_DEC, VALUE_MAX);
        send_item(FUNC_BIN_OCT, 31'd0);
        send_item(FUNC_BIN_OCT, 31'd1111111111);
        send_item(FUNC_BIN_OCT, VALUE_MAX);
        send_item(FUNC_BIN_HEX, 31'd0);
        send_item(FUNC_BIN_HEX, 31'd1010101010);
        send_item(FUNC_BIN_HEX, 31'd999999999);
        send_item(FUNC_OCT_BIN, 31'd0);
        send_item(FUNC_OCT_BIN, 31'd1234567);
        send_item(FUNC_OCT_BIN, VALUE_MAX);
        wait_drained();

        send_random(RANDOM_ITEMS);
        wait_drained();
        send_random(RANDOM_ITEMS);
        wait_drained();
        send_random(RANDOM_ITEMS);
        wait_drained();

        repeat (SETTLE) @(posedge clk);
        if (conv_check.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
